@@ hw/rtl/bzp_pkg.sv @@
// Shared constants, configuration codes and types of the cubic Bezier point evaluator.
// Used by the channel interfaces, the weight generator and the top level.
package bzp_pkg;

  localparam int unsigned CoordW        = 16;
  localparam int unsigned ParamFracBits = 16;
  localparam int unsigned ParamW        = ParamFracBits + 1;
  localparam int unsigned SqW           = 2 * ParamFracBits + 1;
  localparam int unsigned WeightW       = 3 * ParamFracBits + 1;
  localparam int unsigned WeightLoW     = (WeightW + 1) / 2;
  localparam int unsigned WeightHiW     = WeightW - WeightLoW;
  localparam int unsigned NumCoords     = 3;
  localparam int unsigned NumPoints     = 4;
  localparam int unsigned CfgDataW      = 48;
  localparam int unsigned CfgIdxW       = 2;
  localparam int unsigned AccW          = 3 * ParamFracBits + CoordW;
  localparam int unsigned PartLoW       = WeightLoW + CoordW;
  localparam int unsigned PartHiW       = WeightHiW + CoordW;
  localparam int unsigned SumLoW        = PartLoW + 2;
  localparam int unsigned SumHiW        = PartHiW + 2;

  localparam logic [ParamW-1:0]  ParamOne   = {1'b1, {ParamFracBits{1'b0}}};
  localparam logic [WeightW-1:0] WeightOne  = {1'b1, {(WeightW - 1){1'b0}}};
  localparam logic [CoordW-1:0]  CoordSign  = {1'b1, {(CoordW - 1){1'b0}}};
  localparam logic [AccW-1:0]    RoundHalf  =
      {{(AccW - 3 * ParamFracBits){1'b0}}, 1'b1, {(3 * ParamFracBits - 1){1'b0}}};

  typedef enum logic [CfgIdxW-1:0] {
    CFG_CP_A = CfgIdxW'(0),
    CFG_CP_B = CfgIdxW'(1),
    CFG_CP_C = CfgIdxW'(2),
    CFG_CP_D = CfgIdxW'(3)
  } cfg_idx_e;

  // Bernstein weights, scaled by 2^(3*ParamFracBits); they always sum to WeightOne.
  typedef struct packed {
    logic [WeightW-1:0] w0;
    logic [WeightW-1:0] w1;
    logic [WeightW-1:0] w2;
    logic [WeightW-1:0] w3;
  } bzp_weights_t;

endpackage

@@ hw/rtl/bzp_if.sv @@
// Valid/ready channel interfaces: curve parameter words in, curve point words out.
// Depends on bzp_pkg for the field widths.
interface bzp_param_if
  import bzp_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [ParamW-1:0] curve_param;

  modport source (output valid, output curve_param, input ready);
  modport sink   (input valid, input curve_param, output ready);
endinterface

interface bzp_point_if
  import bzp_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic signed [CoordW-1:0] point_x;
  logic signed [CoordW-1:0] point_y;
  logic signed [CoordW-1:0] point_z;

  modport source (output valid, output point_x, output point_y, output point_z, input ready);
  modport sink   (input valid, input point_x, input point_y, input point_z, output ready);
endinterface

@@ hw/rtl/bzp_weight_gen.sv @@
// Four-stage pipeline that turns a curve parameter t into the four cubic Bernstein weights.
// Depends on bzp_pkg; each stage holds its word while the next one is full and stalled.
module bzp_weight_gen
  import bzp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              t_valid_i,
  input  logic [ParamW-1:0] t_i,
  output logic              t_ready_o,
  output logic              w_valid_o,
  input  logic              w_ready_i,
  output bzp_weights_t      w_o
);

  logic v1_q, v2_q, v3_q, v4_q;
  logic en1, en2, en3, en4;

  logic [ParamW-1:0]  t1_q, u1_q;
  logic [ParamW-1:0]  t_sat;
  logic [ParamW-1:0]  ts2_q, us2_q;
  logic [SqW-1:0]     t2_q, u2_q, t2_d, u2_d;
  logic [2*ParamW-1:0] tt_prod, uu_prod;
  logic [WeightW-1:0] w0_q, w3_q, a_q, b_q;
  logic [WeightW-1:0] w0_d, w3_d, a_d, b_d;
  logic [SqW+ParamW-1:0] w0_prod, w3_prod, a_prod, b_prod;
  bzp_weights_t       w_q, w_d;

  // Each stage may load when it is empty or when its word moves on.
  assign en4 = !v4_q || w_ready_i;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;

  assign t_ready_o = en1;
  assign w_valid_o = v4_q;
  assign w_o       = w_q;

  // A parameter beyond one saturates to exactly one.
  assign t_sat = (t_i > ParamOne) ? ParamOne : t_i;

  always_comb begin
    tt_prod = t1_q * t1_q;
    uu_prod = u1_q * u1_q;
    t2_d    = tt_prod[SqW-1:0];
    u2_d    = uu_prod[SqW-1:0];
  end

  always_comb begin
    w0_prod = u2_q * us2_q;
    w3_prod = t2_q * ts2_q;
    a_prod  = u2_q * ts2_q;
    b_prod  = t2_q * us2_q;
    w0_d    = w0_prod[WeightW-1:0];
    w3_d    = w3_prod[WeightW-1:0];
    a_d     = a_prod[WeightW-1:0];
    b_d     = b_prod[WeightW-1:0];
  end

  always_comb begin
    w_d.w0 = w0_q;
    w_d.w1 = a_q + {a_q[WeightW-2:0], 1'b0};
    w_d.w2 = b_q + {b_q[WeightW-2:0], 1'b0};
    w_d.w3 = w3_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= t_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && t_valid_i) begin
      t1_q <= t_sat;
      u1_q <= ParamOne - t_sat;
    end
    if (en2 && v1_q) begin
      t2_q  <= t2_d;
      u2_q  <= u2_d;
      ts2_q <= t1_q;
      us2_q <= u1_q;
    end
    if (en3 && v2_q) begin
      w0_q <= w0_d;
      w3_q <= w3_d;
      a_q  <= a_d;
      b_q  <= b_d;
    end
    if (en4 && v3_q) begin
      w_q <= w_d;
    end
  end

  a_weight_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v4_q |-> ((WeightW + 2)'(w_q.w0) + (WeightW + 2)'(w_q.w1) + (WeightW + 2)'(w_q.w2)
              + (WeightW + 2)'(w_q.w3)) == (WeightW + 2)'(WeightOne))
    else $error("Bernstein weights do not sum to one");

  a_param_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q |-> (t1_q <= ParamOne) && ((t1_q + u1_q) == ParamOne))
    else $error("saturated parameter out of range");

endmodule

@@ hw/rtl/cubic_bezier_point_eval_unit.sv @@
// Cubic Bezier point evaluator: one 3-D point in signed Q4.12 for each parameter t in Q1.16.
// A new parameter word is taken every cycle unless a stall holds the first stage. Every step
// sits behind its own register, so one word can enter per cycle while nothing stalls: four
// stages form the weights, then each weight is multiplied by each coordinate in two halves,
// the halves are summed, and the final stage rounds (ties upward) and registers the result.
// Stalls hold each stage in place and empty stages keep filling, so the input keeps flowing
// while a finished point waits until all seven stages hold a word. The user must write control
// points through the configuration port while the unit is idle; the block does not enforce it.
// Depends on bzp_pkg, bzp_if and bzp_weight_gen.
module cubic_bezier_point_eval_unit
  import bzp_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  bzp_param_if.sink           param_in,
  bzp_point_if.source         point_out,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  logic [CfgDataW-1:0] cp_q [NumPoints];

  logic         w_valid, w_ready;
  bzp_weights_t w_bus;
  logic [WeightW-1:0] w_arr [NumPoints];

  logic v5_q, v6_q, v7_q;
  logic en5, en6, en7;

  logic [PartLoW-1:0] pl_q [NumCoords][NumPoints];
  logic [PartHiW-1:0] ph_q [NumCoords][NumPoints];
  logic [PartLoW-1:0] pl_d [NumCoords][NumPoints];
  logic [PartHiW-1:0] ph_d [NumCoords][NumPoints];
  logic [SumLoW-1:0]  slo_q [NumCoords];
  logic [SumHiW-1:0]  shi_q [NumCoords];
  logic [SumLoW-1:0]  slo_d [NumCoords];
  logic [SumHiW-1:0]  shi_d [NumCoords];
  logic [AccW-1:0]    acc [NumCoords];
  logic [CoordW-1:0]  res_d [NumCoords];
  logic [CoordW-1:0]  res_q [NumCoords];

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumPoints; i++) begin
        cp_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_CP_A: cp_q[0] <= cfg_data_i;
        CFG_CP_B: cp_q[1] <= cfg_data_i;
        CFG_CP_C: cp_q[2] <= cfg_data_i;
        CFG_CP_D: cp_q[3] <= cfg_data_i;
        default:  ;
      endcase
    end
  end

  bzp_weight_gen u_weight_gen (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .t_valid_i (param_in.valid),
    .t_i       (param_in.curve_param),
    .t_ready_o (param_in.ready),
    .w_valid_o (w_valid),
    .w_ready_i (w_ready),
    .w_o       (w_bus)
  );

  assign w_arr[0] = w_bus.w0;
  assign w_arr[1] = w_bus.w1;
  assign w_arr[2] = w_bus.w2;
  assign w_arr[3] = w_bus.w3;

  assign en7     = !v7_q || point_out.ready;
  assign en6     = !v6_q || en7;
  assign en5     = !v5_q || en6;
  assign w_ready = en5;

  // Coordinates are offset to unsigned so that every product is unsigned; the offset is
  // removed again after the shift because the weights sum to exactly one.
  always_comb begin
    logic [CoordW-1:0]    crd;
    logic [WeightLoW-1:0] wl;
    logic [WeightHiW-1:0] wh;
    crd = '0;
    wl  = '0;
    wh  = '0;
    for (int c = 0; c < NumCoords; c++) begin
      for (int i = 0; i < NumPoints; i++) begin
        crd        = cp_q[i][c*CoordW +: CoordW] ^ CoordSign;
        wl         = w_arr[i][WeightLoW-1:0];
        wh         = w_arr[i][WeightW-1:WeightLoW];
        pl_d[c][i] = wl * crd;
        ph_d[c][i] = wh * crd;
      end
    end
  end

  always_comb begin
    for (int c = 0; c < NumCoords; c++) begin
      slo_d[c] = pl_q[c][0] + pl_q[c][1] + pl_q[c][2] + pl_q[c][3];
      shi_d[c] = ph_q[c][0] + ph_q[c][1] + ph_q[c][2] + ph_q[c][3];
    end
  end

  always_comb begin
    for (int c = 0; c < NumCoords; c++) begin
      acc[c]   = AccW'(slo_q[c])
               + {shi_q[c][AccW-WeightLoW-1:0], {WeightLoW{1'b0}}}
               + RoundHalf;
      res_d[c] = acc[c][AccW-1 -: CoordW] ^ CoordSign;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
    end else begin
      if (en5) v5_q <= w_valid;
      if (en6) v6_q <= v5_q;
      if (en7) v7_q <= v6_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en5 && w_valid) begin
      pl_q <= pl_d;
      ph_q <= ph_d;
    end
    if (en6 && v5_q) begin
      slo_q <= slo_d;
      shi_q <= shi_d;
    end
    if (en7 && v6_q) begin
      res_q <= res_d;
    end
  end

  assign point_out.valid   = v7_q;
  assign point_out.point_x = res_q[0];
  assign point_out.point_y = res_q[1];
  assign point_out.point_z = res_q[2];

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !point_out.valid |-> param_in.ready)
    else $error("input refused although the output stage is empty");

  a_partial_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v5_q && !en5) |=> v5_q && $stable(pl_q[0][0]) && $stable(ph_q[2][3]))
    else $error("product stage lost a word during a stall");

  a_sum_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v6_q && !en6) |=> v6_q && $stable(slo_q[1]) && $stable(shi_q[1]))
    else $error("sum stage lost a word during a stall");

endmodule
